@@ sv/iol_pkg.sv @@
// Package for the indexed ordered list: operation and status codes, shared types.
package iol_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int DATA_W       = 32;

   typedef logic [2:0] func_type;
   typedef logic [1:0] status_type;
   typedef logic [6:0] pos_type;

   localparam func_type FUNC_PUSH_FRONT = 3'd0;
   localparam func_type FUNC_PUSH_BACK  = 3'd1;
   localparam func_type FUNC_INSERT     = 3'd2;
   localparam func_type FUNC_REMOVE     = 3'd3;
   localparam func_type FUNC_UPDATE     = 3'd4;
   localparam func_type FUNC_READ       = 3'd5;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_RANGE = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

endpackage

@@ sv/iol_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module iol_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/indexed_ordered_list.sv @@
// Top level of the indexed ordered list: request decode, shift sequencer and result register.
// A refused or ignored request goes straight to the result; a read passes through the RAM
// read wait, and update, insert, pushes and remove through the shift sequencer, which moves
// the elements behind the position one place; a finished item waits while a result is held.
// Throughput: one item at a time, the next accepted the cycle after the result is registered.
// Reset clears the count, sequencer and result valid; RAM contents stay undefined.
module indexed_ordered_list #(
   parameter int CAPACITY = iol_pkg::CAPACITY_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  iol_pkg::func_type               req_func,
   input  iol_pkg::pos_type                req_position,
   input  logic signed [iol_pkg::DATA_W-1:0] req_item_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [iol_pkg::DATA_W-1:0] rsp_read_value,
   output iol_pkg::status_type             rsp_status,
   output iol_pkg::pos_type                rsp_count
);
   import iol_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SHIFT  = 2'd1;
   localparam logic [1:0] ST_RDWAIT = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic [ADDR_W-1:0] rp_ff, rp_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic              pend_ff, pend_in;
   logic              up_ff, up_in;
   logic              fill_ff, fill_in;
   logic [ADDR_W-1:0] fill_addr_ff, fill_addr_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [DATA_W-1:0] rd_ff, rd_in;
   status_type        st_ff, st_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_rd_ff, rsp_rd_in;
   status_type        rsp_st_ff, rsp_st_in;
   pos_type           rsp_cnt_ff, rsp_cnt_in;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [DATA_W-1:0] ram_wdata, ram_rdata;

   logic    accept, out_free;
   pos_type count7, eff_pos;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign count7   = pos_type'(count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      rp_in        = rp_ff;
      pend_addr_in = pend_addr_ff;
      pend_in      = pend_ff;
      up_in        = up_ff;
      fill_in      = fill_ff;
      fill_addr_in = fill_addr_ff;
      val_in       = val_ff;
      rd_in        = rd_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rd_in    = rsp_rd_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      ram_we       = 1'b0;
      ram_waddr    = pend_addr_ff;
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = rp_ff;
      eff_pos      = req_position;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               val_in   = req_item_value;
               rd_in    = '0;
               st_in    = STATUS_OK;
               pend_in  = 1'b0;
               fill_in  = 1'b0;
               left_in  = '0;
               state_in = ST_DONE;
               if (req_func == FUNC_PUSH_FRONT) begin
                  eff_pos = '0;
               end else if (req_func == FUNC_PUSH_BACK) begin
                  eff_pos = count7;
               end
               case (req_func) inside
                  FUNC_PUSH_FRONT, FUNC_PUSH_BACK, FUNC_INSERT: begin
                     if (eff_pos > count7) begin
                        st_in = STATUS_RANGE;
                     end else if (count_ff == CNT_W'(CAPACITY)) begin
                        st_in = STATUS_FULL;
                     end else begin
                        left_in      = CNT_W'(count7 - eff_pos);
                        rp_in        = ADDR_W'(count_ff - 1'b1);
                        up_in        = 1'b1;
                        fill_in      = 1'b1;
                        fill_addr_in = ADDR_W'(eff_pos);
                        count_in     = count_ff + 1'b1;
                        state_in     = ST_SHIFT;
                     end
                  end
                  FUNC_REMOVE: begin
                     if (req_position >= count7) begin
                        st_in = STATUS_RANGE;
                     end else begin
                        left_in  = CNT_W'(count7 - req_position - 7'd1);
                        rp_in    = ADDR_W'(req_position + 7'd1);
                        up_in    = 1'b0;
                        count_in = count_ff - 1'b1;
                        state_in = ST_SHIFT;
                     end
                  end
                  FUNC_UPDATE: begin
                     if (req_position >= count7) begin
                        st_in = STATUS_RANGE;
                     end else begin
                        fill_in      = 1'b1;
                        fill_addr_in = ADDR_W'(req_position);
                        state_in     = ST_SHIFT;
                     end
                  end
                  FUNC_READ: begin
                     if (req_position >= count7) begin
                        st_in = STATUS_RANGE;
                        rd_in = '1;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = ADDR_W'(req_position);
                        state_in  = ST_RDWAIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            if (pend_ff) begin
               ram_we = 1'b1;
            end
            if (left_ff != '0) begin
               ram_re       = 1'b1;
               left_in      = left_ff - 1'b1;
               pend_in      = 1'b1;
               rp_in        = up_ff ? rp_ff - 1'b1 : rp_ff + 1'b1;
               pend_addr_in = up_ff ? rp_ff + 1'b1 : rp_ff - 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (fill_ff) begin
                     ram_we    = 1'b1;
                     ram_waddr = fill_addr_ff;
                     ram_wdata = val_ff;
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_RDWAIT: begin
            rd_in    = ram_rdata;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rd_in    = rd_ff;
               rsp_st_in    = st_ff;
               rsp_cnt_in   = count7;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rp_ff        <= rp_in;
      pend_addr_ff <= pend_addr_in;
      up_ff        <= up_in;
      fill_ff      <= fill_in;
      fill_addr_ff <= fill_addr_in;
      val_ff       <= val_in;
      rd_ff        <= rd_in;
      st_ff        <= st_in;
      rsp_rd_ff    <= rsp_rd_in;
      rsp_st_ff    <= rsp_st_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

   iol_ram #(
      .WIDTH(DATA_W),
      .DEPTH(CAPACITY)
   ) u_elements (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_rd_ff;
   assign rsp_status     = rsp_st_ff;
   assign rsp_count      = rsp_cnt_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("count beyond capacity");

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("shift reads the entry it writes");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (ram_waddr < ADDR_W'(CAPACITY - 1) || ram_waddr == ADDR_W'(CAPACITY - 1)))
      else $error("write beyond capacity");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished item not presented");

   a_write_only_shifting: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_SHIFT))
      else $error("RAM write outside shift");

endmodule
